/* rtl/glyph_blit_8x8_macros.svh */
// assertion macros shared by the glyph blitter modules
`ifndef GLYPH_BLIT_8X8_MACROS_SVH
`define GLYPH_BLIT_8X8_MACROS_SVH

`ifndef SYNTH
`define GB8_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GB8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GB8_ASSERT_IMPL(label, ante, cons, msg)
`define GB8_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/gb8_pkg.sv */
package gb8_pkg;

    localparam int GLYPH_DIM    = 8;
    localparam int GLYPH_PIXELS = GLYPH_DIM * GLYPH_DIM;
    localparam int COL_W        = $clog2(GLYPH_DIM);
    localparam int OFFSET_W     = 16;
    localparam int COLOR_W      = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        MODE_OPAQUE      = 1'b0,
        MODE_TRANSPARENT = 1'b1
    } t_mode;

endpackage

/* rtl/gb8_front.sv */
`include "glyph_blit_8x8_macros.svh"

module gb8_front
    import gb8_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic                    i_operation,
    input  logic [OFFSET_W-1:0]     i_start_offset,
    input  logic [GLYPH_PIXELS-1:0] i_glyph_bits,
    input  logic [COLOR_W-1:0]      i_fore_color,
    input  logic [COLOR_W-1:0]      i_back_color,
    output logic                    o_q_valid,
    input  logic                    i_q_take,
    output t_mode                   o_q_mode,
    output logic [ADDR_BITS-1:0]    o_q_start,
    output logic [GLYPH_PIXELS-1:0] o_q_glyph,
    output logic [COLOR_W-1:0]      o_q_fore,
    output logic [COLOR_W-1:0]      o_q_back
);

    localparam int EXT_W = ADDR_BITS + OFFSET_W;

    t_mode                   r_q_mode  [QUEUE_DEPTH];
    logic [ADDR_BITS-1:0]    r_q_start [QUEUE_DEPTH];
    logic [GLYPH_PIXELS-1:0] r_q_glyph [QUEUE_DEPTH];
    logic [COLOR_W-1:0]      r_q_fore  [QUEUE_DEPTH];
    logic [COLOR_W-1:0]      r_q_back  [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]       r_count;

    t_mode                   in_mode;
    logic [EXT_W-1:0]        start_ext;
    logic                    skip;
    logic                    accept;
    logic                    wr;
    logic                    rd;

    assign in_mode   = t_mode'(i_operation);
    // zero-extend or truncate the 16-bit offset to the address width
    assign start_ext = {{ADDR_BITS{1'b0}}, i_start_offset};
    // a transparent glyph with no set bits produces no writes at all
    assign skip      = (in_mode == MODE_TRANSPARENT) && (i_glyph_bits == '0);
    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign accept    = i_push && !o_full;
    assign wr        = accept && !skip;
    assign o_q_valid = (r_count != '0);
    assign rd        = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q_mode[r_wr_ptr]  <= in_mode;
            r_q_start[r_wr_ptr] <= start_ext[ADDR_BITS-1:0];
            r_q_glyph[r_wr_ptr] <= i_glyph_bits;
            r_q_fore[r_wr_ptr]  <= i_fore_color;
            r_q_back[r_wr_ptr]  <= i_back_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_q_mode  = r_q_mode[r_rd_ptr];
    assign o_q_start = r_q_start[r_rd_ptr];
    assign o_q_glyph = r_q_glyph[r_rd_ptr];
    assign o_q_fore  = r_q_fore[r_rd_ptr];
    assign o_q_back  = r_q_back[r_rd_ptr];

    `GB8_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH),
        "command queue count out of range")
    `GB8_ASSERT_IMPL(a_ptr_gap, 1'b1,
        (r_count == QCNT_W'(QUEUE_DEPTH)) || (r_count == '0) || (r_wr_ptr != r_rd_ptr),
        "queue pointers disagree with count")
    `GB8_ASSERT_NEXT(a_skip_no_write, accept && skip && !rd, $stable(r_count),
        "empty transparent command entered the queue")

endmodule

/* rtl/gb8_raster.sv */
`include "glyph_blit_8x8_macros.svh"

module gb8_raster
    import gb8_pkg::*;
#(
    parameter int SCREEN_WIDTH = 320,
    parameter int ADDR_BITS    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    output logic                    o_q_take,
    input  t_mode                   i_q_mode,
    input  logic [ADDR_BITS-1:0]    i_q_start,
    input  logic [GLYPH_PIXELS-1:0] i_q_glyph,
    input  logic [COLOR_W-1:0]      i_q_fore,
    input  logic [COLOR_W-1:0]      i_q_back,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [OFFSET_W-1:0]     o_pixel_address,
    output logic [COLOR_W-1:0]      o_pixel_color,
    output logic                    o_last_write
);

    localparam int EXT_W = ADDR_BITS + OFFSET_W;

    logic                    r_busy;
    logic [GLYPH_PIXELS-1:0] r_glyph;
    logic [GLYPH_PIXELS-1:0] r_mask;
    logic [COL_W-1:0]        r_col;
    logic [ADDR_BITS-1:0]    r_row_start;
    logic [COLOR_W-1:0]      r_fore;
    logic [COLOR_W-1:0]      r_back;
    logic                    r_out_valid;
    logic [ADDR_BITS-1:0]    r_out_addr;
    logic [COLOR_W-1:0]      r_out_color;
    logic                    r_out_last;

    logic                    pop_ok;
    logic                    out_free;
    logic                    step;
    logic                    finish;
    logic                    emit;
    logic [ADDR_BITS-1:0]    pix_addr;
    logic [EXT_W-1:0]        addr_ext;

    assign pop_ok   = i_pop && r_out_valid;
    assign out_free = !r_out_valid || pop_ok;
    assign step     = r_busy && out_free;
    // no pixel left to draw after the current position
    assign finish   = step && (r_mask[GLYPH_PIXELS-1:1] == '0);
    assign emit     = step && r_mask[0];
    assign o_q_take = i_q_valid && (!r_busy || finish);
    assign pix_addr = r_row_start + ADDR_BITS'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_take) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop_ok) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_take) begin
            r_glyph     <= i_q_glyph;
            r_mask      <= (i_q_mode == MODE_TRANSPARENT) ? i_q_glyph : '1;
            r_col       <= '0;
            r_row_start <= i_q_start;
            r_fore      <= i_q_fore;
            r_back      <= i_q_back;
        end else if (step) begin
            r_glyph <= r_glyph >> 1;
            r_mask  <= r_mask >> 1;
            r_col   <= r_col + 1'b1;
            if (r_col == COL_W'(GLYPH_DIM - 1)) begin
                r_row_start <= r_row_start + ADDR_BITS'(SCREEN_WIDTH);
            end
        end
        if (emit) begin
            r_out_addr  <= pix_addr;
            r_out_color <= r_glyph[0] ? r_fore : r_back;
            r_out_last  <= finish;
        end
    end

    assign addr_ext        = {{OFFSET_W{1'b0}}, r_out_addr};
    assign o_pixel_address = addr_ext[OFFSET_W-1:0];
    assign o_pixel_color   = r_out_color;
    assign o_last_write    = r_out_last;
    assign o_empty         = !r_out_valid;

    `GB8_ASSERT_IMPL(a_busy_has_pixels, r_busy, r_mask != '0,
        "raster active with nothing left to draw")
    `GB8_ASSERT_NEXT(a_take_starts, o_q_take, r_busy,
        "command taken but raster not active")
    `GB8_ASSERT_IMPL(a_emit_needs_room, emit, out_free,
        "pixel written over a waiting result")

endmodule

/* rtl/glyph_blit_8x8.sv */
// 8x8 monochrome glyph blitter. Each accepted command expands into framebuffer
// writes in row-major order at start + row*SCREEN_WIDTH + column, wrapped to
// ADDR_BITS; opaque commands give 64 writes, transparent ones one write per
// set bit, the last carrying o_last_write. A two-entry command queue sits in
// front of the raster unit, which walks one glyph position per cycle unless
// its output register is full; a transparent command with no set bits is
// dropped on entry. The next command is loaded in the cycle the previous one
// finishes. Writes leave through a one-entry output register, so the raster
// walk stalls only while a finished write is still not popped.
module glyph_blit_8x8
    import gb8_pkg::*;
#(
    parameter int SCREEN_WIDTH = 320,
    parameter int ADDR_BITS    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_operation,
    input  logic [OFFSET_W-1:0]     i_start_offset,
    input  logic [GLYPH_PIXELS-1:0] i_glyph_bits,
    input  logic [COLOR_W-1:0]      i_fore_color,
    input  logic [COLOR_W-1:0]      i_back_color,
    output logic                    empty,
    input  logic                    pop,
    output logic [OFFSET_W-1:0]     o_pixel_address,
    output logic [COLOR_W-1:0]      o_pixel_color,
    output logic                    o_last_write
);

    logic                    q_valid;
    logic                    q_take;
    t_mode                   q_mode;
    logic [ADDR_BITS-1:0]    q_start;
    logic [GLYPH_PIXELS-1:0] q_glyph;
    logic [COLOR_W-1:0]      q_fore;
    logic [COLOR_W-1:0]      q_back;

    gb8_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_operation    (i_operation),
        .i_start_offset (i_start_offset),
        .i_glyph_bits   (i_glyph_bits),
        .i_fore_color   (i_fore_color),
        .i_back_color   (i_back_color),
        .o_q_valid      (q_valid),
        .i_q_take       (q_take),
        .o_q_mode       (q_mode),
        .o_q_start      (q_start),
        .o_q_glyph      (q_glyph),
        .o_q_fore       (q_fore),
        .o_q_back       (q_back)
    );

    gb8_raster #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .ADDR_BITS    (ADDR_BITS)
    ) u_raster (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_q_take        (q_take),
        .i_q_mode        (q_mode),
        .i_q_start       (q_start),
        .i_q_glyph       (q_glyph),
        .i_q_fore        (q_fore),
        .i_q_back        (q_back),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_write    (o_last_write)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import gb8_pkg::*;

    localparam int SCREEN_W        = 320;
    localparam int ADDR_W          = 16;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_W) - 1);
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int ITEMS_PER_PHASE = 64;

    typedef struct packed {
        logic [OFFSET_W-1:0] addr;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } t_pixel_write;

    // expands each accepted glyph into the framebuffer writes it must produce
    class blit_tracker;
        t_pixel_write due_writes[$];
        int errors = 0;

        function void expand_glyph(t_mode mode, logic [OFFSET_W-1:0] start,
                                   logic [GLYPH_PIXELS-1:0] glyph,
                                   logic [COLOR_W-1:0] fore, logic [COLOR_W-1:0] back);
            logic [31:0]  row_base;
            logic [31:0]  addr;
            t_pixel_write w;
            int           first_new;
            first_new = due_writes.size();
            row_base = 32'(start) & ADDR_MASK;
            for (int r = 0; r < GLYPH_DIM; r++) begin
                for (int c = 0; c < GLYPH_DIM; c++) begin
                    if (glyph[r*GLYPH_DIM + c] || mode == MODE_OPAQUE) begin
                        addr    = (row_base + 32'(c)) & ADDR_MASK;
                        w.addr  = addr[OFFSET_W-1:0];
                        w.color = glyph[r*GLYPH_DIM + c] ? fore : back;
                        w.last  = 1'b0;
                        due_writes.push_back(w);
                    end
                end
                row_base = (row_base + 32'(SCREEN_W)) & ADDR_MASK;
            end
            if (due_writes.size() > first_new) begin
                w = due_writes.pop_back();
                w.last = 1'b1;
                due_writes.push_back(w);
            end
        endfunction

        function void compare_write(logic [OFFSET_W-1:0] addr, logic [COLOR_W-1:0] color,
                                    logic last);
            t_pixel_write want;
            if (due_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write, expected none, got addr %h color %h last %b",
                         $time, addr, color, last);
                return;
            end
            want = due_writes.pop_front();
            if (want.addr !== addr) begin
                errors++;
                $display("%0t: pixel_address expected %h, got %h", $time, want.addr, addr);
            end
            if (want.color !== color) begin
                errors++;
                $display("%0t: pixel_color expected %h, got %h", $time, want.color, color);
            end
            if (want.last !== last) begin
                errors++;
                $display("%0t: last_write expected %b, got %b", $time, want.last, last);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic                    i_operation;
    logic [OFFSET_W-1:0]     i_start_offset;
    logic [GLYPH_PIXELS-1:0] i_glyph_bits;
    logic [COLOR_W-1:0]      i_fore_color;
    logic [COLOR_W-1:0]      i_back_color;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [OFFSET_W-1:0]     o_pixel_address;
    logic [COLOR_W-1:0]      o_pixel_color;
    logic                    o_last_write;

    blit_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    glyph_blit_8x8 #(
        .SCREEN_WIDTH (SCREEN_W),
        .ADDR_BITS    (ADDR_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_operation     (i_operation),
        .i_start_offset  (i_start_offset),
        .i_glyph_bits    (i_glyph_bits),
        .i_fore_color    (i_fore_color),
        .i_back_color    (i_back_color),
        .empty           (empty),
        .pop             (pop),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_write    (o_last_write)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[glyph_blit_8x8] ERROR");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            tracker.compare_write(o_pixel_address, o_pixel_color, o_last_write);
    end

    task automatic send_glyph(t_mode mode, logic [OFFSET_W-1:0] start,
                              logic [GLYPH_PIXELS-1:0] glyph,
                              logic [COLOR_W-1:0] fore, logic [COLOR_W-1:0] back);
        push           <= 1'b1;
        i_operation    <= mode;
        i_start_offset <= start;
        i_glyph_bits   <= glyph;
        i_fore_color   <= fore;
        i_back_color   <= back;
        do @(posedge i_clk); while (full);
        tracker.expand_glyph(mode, start, glyph, fore, back);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic pause_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (tracker.due_writes.size() != 0);
    endtask

    function automatic logic [GLYPH_PIXELS-1:0] rand_glyph();
        logic [GLYPH_PIXELS-1:0] g;
        case ($urandom_range(9))
            0: g = '0;
            1: g = '1;
            2: g = {{(GLYPH_PIXELS-1){1'b0}}, 1'b1} << $urandom_range(GLYPH_PIXELS-1);
            3, 4: begin
                g = '0;
                repeat ($urandom_range(1, 6)) g[$urandom_range(GLYPH_PIXELS-1)] = 1'b1;
            end
            default: g = {$urandom, $urandom};
        endcase
        return g;
    endfunction

    task automatic send_random();
        t_mode               mode;
        logic [OFFSET_W-1:0] start;
        mode = t_mode'($urandom_range(1));
        // a quarter of the glyphs sit near the top of the address space to wrap
        if ($urandom_range(3) == 0)
            start = 16'hFFFF - 16'($urandom_range(2600));
        else
            start = 16'($urandom_range(65535));
        send_glyph(mode, start, rand_glyph(), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_operation    <= MODE_OPAQUE;
        i_start_offset <= '0;
        i_glyph_bits   <= '0;
        i_fore_color   <= '0;
        i_back_color   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_glyph(MODE_OPAQUE,      16'h0000, 64'h0, 8'hFF, 8'h00);
        send_glyph(MODE_OPAQUE,      16'h1234, '1, 8'h00, 8'hFF);
        // empty transparent glyph makes no writes
        send_glyph(MODE_TRANSPARENT, 16'h0100, 64'h0, 8'hAA, 8'h55);
        send_glyph(MODE_TRANSPARENT, 16'h0200, '1, 8'h5A, 8'hA5);
        send_glyph(MODE_TRANSPARENT, 16'h0300, 64'h1, 8'h11, 8'h22);
        send_glyph(MODE_TRANSPARENT, 16'h0400, 64'h8000_0000_0000_0000, 8'h33, 8'h44);
        send_glyph(MODE_OPAQUE,      16'hFFFF, 64'h55AA_55AA_55AA_55AA, 8'hC3, 8'h3C);
        send_glyph(MODE_OPAQUE,      16'hFC3F, 64'hAA55_AA55_AA55_AA55, 8'h01, 8'hFE);
        send_glyph(MODE_TRANSPARENT, 16'hFFFC, 64'hAAAA_AAAA_AAAA_AAAA, 8'h80, 8'h7F);
        send_glyph(MODE_OPAQUE,      16'h8000, 64'h0102_0408_1020_4080, 8'h0F, 8'hF0);
        // back color must be ignored here
        send_glyph(MODE_TRANSPARENT, 16'h7FFF, 64'hFF00_FF00_FF00_FF00, 8'h00, 8'hFF);
        send_glyph(MODE_TRANSPARENT, 16'h0500, 64'h0, 8'hFF, 8'hFF);
        send_glyph(MODE_TRANSPARENT, 16'h0600, 64'h0, 8'h00, 8'h00);
        send_glyph(MODE_OPAQUE,      16'hFEC0, 64'h0123_4567_89AB_CDEF, 8'hFF, 8'hFF);
        pause_until_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while commands keep coming
                if (p == 0 && n == 8)
                    hold_req++;
                send_random();
                sender_gap();
            end
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.due_writes.size() == 0)
            $display("[glyph_blit_8x8] OK");
        else
            $display("[glyph_blit_8x8] ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/gb8_pkg.sv
rtl/gb8_front.sv
rtl/gb8_raster.sv
rtl/glyph_blit_8x8.sv
dv/tb_top.sv
